// ===== sv/refcount_compacting_object_pool_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the object pool core
// Shared helpers for concurrent checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef REFCOUNT_COMPACTING_OBJECT_POOL_CORE_MACROS_SVH
`define REFCOUNT_COMPACTING_OBJECT_POOL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RCOP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RCOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCOP_ASSERT_SAME(lbl, ante, cons, msg)
`define RCOP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/rcop_pkg.sv =====
// ----------------------------------------------------------------------------
// Object pool package
// Sizes, codes and shared types of the object pool core.
// ----------------------------------------------------------------------------
package rcop_pkg;
    localparam int POOL_BYTES  = 65536;
    localparam int MAX_OBJECTS = 64;
    localparam int IDX_W       = $clog2(MAX_OBJECTS);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [1:0] K_INSERT   = 2'd0;
    localparam logic [1:0] K_RETRIEVE = 2'd1;
    localparam logic [1:0] K_ADD      = 2'd2;
    localparam logic [1:0] K_DROP     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [31:0] handle;
        logic [15:0] len;
        logic [15:0] off;
        logic [31:0] refs;
        logic        live;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_SWAP,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic             parity;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_entry;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_LOOK,
        S_PACK,
        S_SQZ,
        S_DONE
    } t_state;
endpackage

// ===== sv/refcount_compacting_object_pool_core.sv =====
// ----------------------------------------------------------------------------
// Reference-counting compacting object pool core
// Object table held in a ring of cells; lookup, count update and compaction
// rotate the ring past a fixed tap at the top cell, compaction also swaps cells.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                             tuser
//  s_axis   in   size[15:0] ref_id[47:16]                          kind
//  m_axis   out  handle[31:0] offset[47:32] bank[48] compacted[49] status
//                objects_live[56:50]
//
// An insert that fits is written straight into the table; retrieve, add and
// drop each run one full rotation of the cell ring.
// A compacting insert runs a rotation to pack offsets and MAX_OBJECTS rounds
// of neighbour swaps to squeeze out dead cells, then retries the insert.
// Reset clears the counters; the table holds no reset and needs no sweep.
// A new word is taken while a finished result still waits at the output.
module refcount_compacting_object_pool_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // size, ref_id
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // handle, offset, bank, compacted, objects_live
    output logic [1:0]  m_axis_tuser   // status
);
    import rcop_pkg::*;
    `include "refcount_compacting_object_pool_core_macros.svh"

    localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_OBJECTS - 1);

    t_entry    ent [MAX_OBJECTS];
    t_entry    tap;
    t_entry    wrap;
    t_entry    tie;
    t_cell_ctl ctl;

    t_state            r_state, n_state;
    logic [1:0]        r_kind, n_kind;
    logic [15:0]       r_size, n_size;
    logic [31:0]       r_ref, n_ref;
    logic [IDX_W-1:0]  r_step, n_step;
    logic              r_found, n_found;
    logic [15:0]       r_hit_off, n_hit_off;
    logic              r_comp, n_comp;
    logic [15:0]       r_pos, n_pos;
    logic [CNT_W-1:0]  r_kept, n_kept;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [15:0]       r_free, n_free;
    logic [31:0]       r_next, n_next;
    logic              r_bank, n_bank;
    logic [1:0]        r_st, n_st;
    logic [31:0]       r_hnd, n_hnd;
    logic [15:0]       r_off, n_off;
    logic              r_ovalid, n_ovalid;
    logic [63:0]       r_odata, n_odata;
    logic [1:0]        r_ouser, n_ouser;

    logic             accept;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             hit;
    logic             need;
    logic             full;
    logic             out_free;
    logic             last;
    logic [31:0]      next_inc;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign tap      = ent[MAX_OBJECTS-1];
    assign idx      = LAST - r_step;
    assign in_range = {1'b0, idx} < r_count;
    assign hit      = !r_found && in_range && (tap.handle == r_ref);
    assign need     = ({1'b0, r_free} + {1'b0, r_size}) >= 17'(POOL_BYTES);
    assign full     = r_count >= CNT_W'(MAX_OBJECTS);
    assign out_free = !r_ovalid || m_axis_tready;
    assign last     = r_step == LAST;
    assign next_inc = r_next + 32'd1;
    assign tie      = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_OBJECTS; gi++) begin : g_cell
            t_entry below;
            t_entry above;
            if (gi == 0) begin : g_bot
                assign below = wrap;
            end else begin : g_mid
                assign below = ent[gi-1];
            end
            if (gi == MAX_OBJECTS - 1) begin : g_top
                assign above = tie;
            end else begin : g_low
                assign above = ent[gi+1];
            end
            rcop_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(gi)),
                .i_ctl   (ctl),
                .i_below (below),
                .i_above (above),
                .o_entry (ent[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == K_INSERT) ? S_INS : S_LOOK;
                end
            end
            S_INS: begin
                n_state = (!r_comp && (need || full)) ? S_PACK : S_DONE;
            end
            S_LOOK: begin
                if (last) begin
                    n_state = S_DONE;
                end
            end
            S_PACK: begin
                if (last) begin
                    n_state = S_SQZ;
                end
            end
            S_SQZ: begin
                if (last) begin
                    n_state = S_INS;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        n_kind    = r_kind;
        n_size    = r_size;
        n_ref     = r_ref;
        n_step    = r_step;
        n_found   = r_found;
        n_hit_off = r_hit_off;
        n_comp    = r_comp;
        n_pos     = r_pos;
        n_kept    = r_kept;
        n_count   = r_count;
        n_free    = r_free;
        n_next    = r_next;
        n_bank    = r_bank;
        n_st      = r_st;
        n_hnd     = r_hnd;
        n_off     = r_off;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        n_ouser   = r_ouser;
        wrap      = tap;
        ctl.op       = CELL_HOLD;
        ctl.parity   = r_step[0];
        ctl.wr_idx   = r_count[IDX_W-1:0];
        ctl.wr_entry = '{handle: r_next, len: r_size, off: r_free, refs: 32'd1, live: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind  = s_axis_tuser;
                    n_size  = s_axis_tdata[15:0];
                    n_ref   = s_axis_tdata[47:16];
                    n_step  = '0;
                    n_found = 1'b0;
                    n_comp  = 1'b0;
                end
            end
            S_INS: begin
                n_hnd = '0;
                n_off = '0;
                if (!r_comp && (need || full)) begin
                    n_comp = 1'b1;
                    n_step = '0;
                    n_pos  = '0;
                    n_kept = '0;
                end else if (need) begin
                    n_st = ST_NOSPACE;
                end else if (full) begin
                    n_st = ST_FULL;
                end else begin
                    ctl.op  = CELL_WRITE;
                    n_st    = ST_OK;
                    n_hnd   = r_next;
                    n_off   = r_free;
                    n_free  = r_free + r_size;
                    n_count = r_count + CNT_W'(1);
                    n_next  = (next_inc == 32'd0) ? 32'd1 : next_inc;
                end
            end
            S_LOOK: begin
                ctl.op = CELL_ROT;
                n_step = r_step + IDX_W'(1);
                if (hit) begin
                    n_found   = 1'b1;
                    n_hit_off = tap.off;
                    if (r_kind == K_ADD && tap.refs != 32'hFFFF_FFFF) begin
                        wrap.refs = tap.refs + 32'd1;
                    end else if (r_kind == K_DROP && tap.refs != 32'd0) begin
                        wrap.refs = tap.refs - 32'd1;
                    end
                end
                if (last) begin
                    n_hnd = '0;
                    n_st  = n_found ? ST_OK : ST_NOTFOUND;
                    n_off = (n_found && r_kind == K_RETRIEVE) ? n_hit_off : 16'd0;
                end
            end
            S_PACK: begin
                ctl.op    = CELL_ROT;
                n_step    = r_step + IDX_W'(1);
                wrap.live = in_range && (tap.refs != 32'd0);
                if (wrap.live) begin
                    wrap.off = r_pos;
                    n_pos    = r_pos + tap.len;
                    n_kept   = r_kept + CNT_W'(1);
                end
            end
            S_SQZ: begin
                ctl.op    = CELL_SWAP;
                wrap.live = 1'b1;
                n_step    = r_step + IDX_W'(1);
                if (last) begin
                    n_count = r_kept;
                    n_free  = r_pos;
                    n_bank  = !r_bank;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_st;
                    n_odata  = {7'd0, r_count, r_comp, r_bank, r_off, r_hnd};
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_free   <= '0;
            r_next   <= 32'd1;
            r_bank   <= 1'b0;
            r_ovalid <= 1'b0;
            r_comp   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_free   <= n_free;
            r_next   <= n_next;
            r_bank   <= n_bank;
            r_ovalid <= n_ovalid;
            r_comp   <= n_comp;
        end
        r_kind    <= n_kind;
        r_size    <= n_size;
        r_ref     <= n_ref;
        r_step    <= n_step;
        r_found   <= n_found;
        r_hit_off <= n_hit_off;
        r_pos     <= n_pos;
        r_kept    <= n_kept;
        r_st      <= n_st;
        r_hnd     <= n_hnd;
        r_off     <= n_off;
        r_odata   <= n_odata;
        r_ouser   <= n_ouser;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    `RCOP_ASSERT_SAME(a_count_max, 1'b1, r_count <= CNT_W'(MAX_OBJECTS), "object count overflow")
    `RCOP_ASSERT_NEXT(a_busy_after_accept, accept, r_state != S_IDLE, "idle after accept")
    `RCOP_ASSERT_NEXT(a_bank_flip, (r_state == S_SQZ) && last, r_bank != $past(r_bank), "bank kept")
endmodule

// ===== sv/rcop_cell.sv =====
// ----------------------------------------------------------------------------
// Object pool table cell
// Holds one table entry; rotates, swaps with a neighbour or is written.
// ----------------------------------------------------------------------------
module rcop_cell (
    input  logic                        i_clk,
    input  logic [rcop_pkg::IDX_W-1:0]  i_index,
    input  rcop_pkg::t_cell_ctl         i_ctl,
    input  rcop_pkg::t_entry            i_below,
    input  rcop_pkg::t_entry            i_above,
    output rcop_pkg::t_entry            o_entry
);
    import rcop_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   lower;
    logic   swap;

    always_comb begin
        lower = (i_index[0] == i_ctl.parity);
        if (lower) begin
            swap = !r_entry.live && i_above.live;
        end else begin
            swap = !i_below.live && r_entry.live;
        end
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_ROT: begin
                n_entry = i_below;
            end
            CELL_SWAP: begin
                if (swap) begin
                    n_entry = lower ? i_above : i_below;
                end
            end
            CELL_WRITE: begin
                if (i_ctl.wr_idx == i_index) begin
                    n_entry = i_ctl.wr_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule
